// ===== rtl/core/tcce_pkg.sv =====
// Shared types and constants for the text console character engine.
package tcce_pkg;

   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int IDX_W   = 11;
   localparam int ATTR_W  = 8;
   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 16;
   localparam int MAX_RES = 3;
   localparam int CNT_W   = 2;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_CURSOR = 2'd3
   } kind_type;

   typedef enum logic {
      ACTION_PUT   = 1'b0,
      ACTION_CLEAR = 1'b1
   } action_type;

   typedef struct packed {
      kind_type             kind;
      logic [IDX_W-1:0]     cell_index;
      logic [VALUE_W-1:0]   cell_value;
      logic                 last;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]     count;
      result_type [MAX_RES-1:0] res;
   } batch_type;

endpackage

// ===== rtl/core/tcce_step.sv =====
// Combinational handling of one item: new cursor position and its result batch.
module tcce_step
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              action,
   input  logic [CHAR_W-1:0] char_code,
   input  logic [ATTR_W-1:0] attr,
   input  logic [COL_W-1:0]  col,
   input  logic [ROW_W-1:0]  row,
   output logic [COL_W-1:0]  col_next,
   output logic [ROW_W-1:0]  row_next,
   output batch_type         batch
);

   localparam int PROD_W = ROW_W + COL_W;

   function automatic logic [IDX_W-1:0] cell_at(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
      logic [PROD_W-1:0] p;
      p = PROD_W'(r) * PROD_W'(COLUMNS) + PROD_W'(c);
      return p[IDX_W-1:0];
   endfunction

   logic [COL_W:0]   col_inc;
   logic [COL_W:0]   col_tab;
   logic [ROW_W-1:0] row_inc;
   logic [ROW_W-1:0] row_raw;
   logic [ROW_W-1:0] row_fin;
   logic [COL_W-1:0] col_raw;
   logic             tail;
   logic             scroll;
   logic [CNT_W-1:0] pre;
   logic [CNT_W-1:0] n;
   logic [VALUE_W-1:0] fill;
   result_type [MAX_RES-1:0] res;

   assign col_inc = {1'b0, col} + (COL_W+1)'(1);
   assign col_tab = (({1'b0, col} + (COL_W+1)'(7)) & ~(COL_W+1)'(7)) + (COL_W+1)'(1);
   assign row_inc = row + ROW_W'(1);
   assign fill    = {attr, 8'h00};

   always_comb begin
      res     = '0;
      pre     = '0;
      tail    = 1'b0;
      col_raw = col;
      row_raw = row;
      if (action == ACTION_CLEAR) begin
         res[0].kind       = KIND_CLEAR;
         res[0].cell_value = fill;
         col_raw           = '0;
         row_raw           = '0;
      end else begin
         case (char_code)
            CHAR_NEWLINE: begin
               col_raw = '0;
               row_raw = row_inc;
               tail    = 1'b1;
            end
            CHAR_BACKSPACE: begin
               col_raw           = (col == '0) ? '0 : col - COL_W'(1);
               res[0].kind       = KIND_WRITE;
               res[0].cell_index = cell_at(row, col_raw);
               res[0].cell_value = {attr, CHAR_SPACE};
            end
            CHAR_TAB: begin
               tail = 1'b1;
               if (col_tab >= (COL_W+1)'(COLUMNS)) begin
                  col_raw = '0;
                  row_raw = row_inc;
               end else begin
                  col_raw = col_tab[COL_W-1:0];
               end
            end
            default: begin
               tail = 1'b1;
               if (!char_code[CHAR_W-1]) begin
                  res[0].kind       = KIND_WRITE;
                  res[0].cell_index = cell_at(row, col);
                  res[0].cell_value = {attr, char_code};
                  pre               = CNT_W'(1);
               end
               if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                  col_raw = '0;
                  row_raw = row_inc;
               end else begin
                  col_raw = col_inc[COL_W-1:0];
               end
            end
         endcase
      end

      scroll  = tail && (row_raw >= ROW_W'(ROWS));
      row_fin = scroll ? ROW_W'(ROWS - 1) : row_raw;
      n       = CNT_W'(1);
      if (tail) begin
         if (scroll) begin
            res[pre].kind       = KIND_SCROLL;
            res[pre].cell_index = '0;
            res[pre].cell_value = fill;
         end
         n = pre + CNT_W'(scroll);
         res[n].kind       = KIND_CURSOR;
         res[n].cell_index = cell_at(row_fin, col_raw);
         res[n].cell_value = '0;
         n = n + CNT_W'(1);
      end
      for (int i = 0; i < MAX_RES; i++) begin
         res[i].last = (CNT_W'(i) == n - CNT_W'(1));
      end
   end

   assign col_next    = col_raw;
   assign row_next    = row_fin;
   assign batch.count = n;
   assign batch.res   = res;

endmodule

// ===== rtl/core/tcce_queue.sv =====
// Three-entry result register that hands out one result item per cycle while pop is asserted.
module tcce_queue
   import tcce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  batch_type  batch,
   input  logic       pop,
   output logic       empty,
   output logic       one_left,
   output result_type head
);

   result_type [MAX_RES-1:0] q_ff;
   result_type [MAX_RES-1:0] q_in;
   logic [CNT_W-1:0]         cnt_ff;
   logic [CNT_W-1:0]         cnt_in;

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (load) begin
         q_in   = batch.res;
         cnt_in = batch.count;
      end else if (pop) begin
         for (int i = 0; i < MAX_RES - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

   assign empty    = (cnt_ff == '0);
   assign one_left = (cnt_ff == CNT_W'(1));
   assign head     = q_ff[0];

endmodule

// ===== rtl/core/text_console_character_engine_top.sv =====
// Top level of the text console character engine.
// Each accepted item is decoded in the cycle it arrives and its one to three results
// (cell write, scroll, cursor update, or a single clear) are loaded into a three-entry
// result register that drives the result channel, one result per cycle while the receiver
// is ready. An item therefore occupies the block until all of its results are taken, and
// the next item is accepted in the same cycle that the last result of the previous one
// is taken. The attribute register may be written at any time the block is idle.
module text_console_character_engine_top
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic [CHAR_W-1:0]    req_char_code,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [IDX_W-1:0]     rsp_cell_index,
   output logic [VALUE_W-1:0]   rsp_cell_value,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ATTR_W-1:0]    csr_text_attribute
);

   logic [ATTR_W-1:0] attr_ff;
   logic [ATTR_W-1:0] attr_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [COL_W-1:0]  col_next;
   logic [ROW_W-1:0]  row_next;
   batch_type         batch;
   result_type        head;
   logic              empty;
   logic              one_left;
   logic              accept;
   logic              pop;

   tcce_step #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_step (
      .action    (req_action),
      .char_code (req_char_code),
      .attr      (attr_ff),
      .col       (col_ff),
      .row       (row_ff),
      .col_next  (col_next),
      .row_next  (row_next),
      .batch     (batch)
   );

   tcce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .batch    (batch),
      .pop      (pop),
      .empty    (empty),
      .one_left (one_left),
      .head     (head)
   );

   assign rsp_valid = !empty;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = !reset && (empty || (one_left && rsp_ready));
   assign accept    = req_valid && req_ready;
   assign csr_ready = !reset;

   assign attr_in = (csr_valid && csr_ready) ? csr_text_attribute : attr_ff;
   assign col_in  = accept ? col_next : col_ff;
   assign row_in  = accept ? row_next : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         attr_ff <= attr_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   assign rsp_kind       = head.kind;
   assign rsp_cell_index = head.cell_index;
   assign rsp_cell_value = head.cell_value;
   assign rsp_last       = head.last;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the text console character engine.
`timescale 1ns / 1ps

module tb_top;
   import tcce_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;

   typedef struct {
      action_type          act;
      logic [CHAR_W-1:0]   code;
   } console_item_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_action = 1'b0;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_kind;
   logic [IDX_W-1:0]     rsp_cell_index;
   logic [VALUE_W-1:0]   rsp_cell_value;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [ATTR_W-1:0]    csr_text_attribute = '0;

   console_item_type     pending_items [$];
   result_type           console_cmds_due [$];
   result_type           staged [MAX_RES];
   int                   staged_n;

   int unsigned          model_col = 0;
   int unsigned          model_row = 0;
   logic [ATTR_W-1:0]    model_attr = ATTR_RESET;

   int                   items_issued = 0;
   int                   items_accepted = 0;
   int                   mismatches = 0;
   int                   hold_requests = 0;
   bit                   req_taken = 1'b0;
   bit                   rsp_taken = 1'b0;

   text_console_character_engine_top #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [IDX_W-1:0] cell_here();
      return IDX_W'(model_row * COLUMNS + model_col);
   endfunction

   function automatic void stage_cmd(kind_type kind, logic [IDX_W-1:0] idx,
                                     logic [VALUE_W-1:0] value);
      staged[staged_n] = '{kind: kind, cell_index: idx, cell_value: value, last: 1'b0};
      staged_n++;
   endfunction

   function automatic void stage_scroll_cursor();
      if (model_row >= ROWS) begin
         stage_cmd(KIND_SCROLL, '0, {model_attr, 8'h00});
         model_row = ROWS - 1;
      end
      stage_cmd(KIND_CURSOR, cell_here(), '0);
   endfunction

   function automatic void predict_console_cmds(action_type act, logic [CHAR_W-1:0] code);
      int unsigned next_col;
      staged_n = 0;
      if (act == ACTION_CLEAR) begin
         stage_cmd(KIND_CLEAR, '0, {model_attr, 8'h00});
         model_col = 0;
         model_row = 0;
      end else if (code == CHAR_NEWLINE) begin
         model_col = 0;
         model_row++;
         stage_scroll_cursor();
      end else if (code == CHAR_BACKSPACE) begin
         if (model_col > 0)
            model_col--;
         stage_cmd(KIND_WRITE, cell_here(), {model_attr, CHAR_SPACE});
      end else if (code == CHAR_TAB) begin
         next_col = ((model_col + 7) & 32'hFFFF_FFF8) + 1;
         if (next_col >= COLUMNS) begin
            next_col = 0;
            model_row++;
         end
         model_col = next_col;
         stage_scroll_cursor();
      end else begin
         if (code < 8'd128)
            stage_cmd(KIND_WRITE, cell_here(), {model_attr, code});
         model_col++;
         if (model_col >= COLUMNS) begin
            model_col = 0;
            model_row++;
         end
         stage_scroll_cursor();
      end
      staged[staged_n-1].last = 1'b1;
      for (int i = 0; i < staged_n; i++)
         console_cmds_due.push_back(staged[i]);
   endfunction

   function automatic int draw_idle(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_left = $urandom_range(5, 30);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   always @(posedge clock) begin
      result_type due;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (console_cmds_due.size() == 0) begin
               $error("unexpected item: kind %0d, cell_index %0d, cell_value %h, last %0d",
                      rsp_kind, rsp_cell_index, rsp_cell_value, rsp_last);
               mismatches++;
            end else begin
               due = console_cmds_due.pop_front();
               if (rsp_kind !== due.kind) begin
                  $error("kind: expected %0d, actual %0d", due.kind, rsp_kind);
                  mismatches++;
               end
               if (rsp_cell_index !== due.cell_index) begin
                  $error("cell_index: expected %0d, actual %0d", due.cell_index,
                         rsp_cell_index);
                  mismatches++;
               end
               if (rsp_cell_value !== due.cell_value) begin
                  $error("cell_value: expected %h, actual %h", due.cell_value,
                         rsp_cell_value);
                  mismatches++;
               end
               if (rsp_last !== due.last) begin
                  $error("last: expected %0d, actual %0d", due.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            items_accepted++;
            predict_console_cmds(action_type'(req_action), req_char_code);
         end
      end
   end

   always @(negedge clock) begin
      console_item_type item;
      int gap_left;
      int send_calm;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         send_calm = 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            item = pending_items.pop_front();
            req_action <= item.act;
            req_char_code <= item.code;
            req_valid <= 1'b1;
            gap_left = draw_idle(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      int stall_left;
      int hold_left;
      int hold_seen;
      int recv_calm;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
         hold_seen = 0;
         recv_calm = 0;
      end else begin
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = 200;
         end
         if (rsp_taken)
            stall_left = draw_idle(recv_calm);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_item(input action_type act, input logic [CHAR_W-1:0] code);
      pending_items.push_back('{act: act, code: code});
      items_issued++;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (items_accepted != items_issued || console_cmds_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_text_attribute <= value;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      model_attr = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_segment();
      int len;
      case ($urandom_range(0, 11))
         0, 1, 2, 3: begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 25);
            repeat (len) queue_item(ACTION_PUT, 8'($urandom_range(32, 126)));
         end
         4, 5: begin
            repeat ($urandom_range(1, 8)) queue_item(ACTION_PUT, CHAR_NEWLINE);
         end
         6: begin
            repeat ($urandom_range(1, 12)) queue_item(ACTION_PUT, CHAR_TAB);
         end
         7: begin
            repeat ($urandom_range(1, 10)) queue_item(ACTION_PUT, CHAR_BACKSPACE);
         end
         8, 9: begin
            repeat ($urandom_range(1, 10))
               queue_item(($urandom_range(0, 15) == 0) ? ACTION_CLEAR : ACTION_PUT,
                          8'($urandom_range(0, 255)));
         end
         10: begin
            repeat ($urandom_range(0, 20)) queue_item(ACTION_PUT, 8'($urandom_range(32, 126)));
            queue_item(ACTION_PUT, CHAR_NEWLINE);
         end
         default: begin
            queue_item(ACTION_CLEAR, 8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   initial begin
      int phase_end;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The attribute keeps its reset value for this first part.
      queue_item(ACTION_PUT, 8'd65);
      queue_item(ACTION_PUT, 8'd0);
      queue_item(ACTION_PUT, 8'd127);
      queue_item(ACTION_PUT, 8'd128);
      queue_item(ACTION_PUT, 8'd255);
      queue_item(ACTION_PUT, CHAR_BACKSPACE);
      queue_item(ACTION_PUT, CHAR_TAB);
      queue_item(ACTION_PUT, CHAR_TAB);
      queue_item(ACTION_PUT, CHAR_NEWLINE);
      queue_item(ACTION_PUT, CHAR_BACKSPACE);
      queue_item(ACTION_PUT, CHAR_TAB);
      queue_item(ACTION_PUT, CHAR_BACKSPACE);
      queue_item(ACTION_PUT, CHAR_BACKSPACE);
      queue_item(ACTION_PUT, CHAR_SPACE);
      queue_item(ACTION_PUT, 8'd13);
      queue_item(ACTION_CLEAR, 8'hFF);
      queue_item(ACTION_PUT, 8'd126);
      queue_item(ACTION_CLEAR, CHAR_NEWLINE);
      queue_item(ACTION_PUT, CHAR_NEWLINE);
      wait_drained();

      // Enough line feeds to push the cursor past the bottom row.
      write_attribute(8'h00);
      repeat (26) queue_item(ACTION_PUT, CHAR_NEWLINE);
      wait_drained();

      // Tabs and a long text run both wrap past the right edge. The receiver then
      // holds off for a long stretch so that the engine fills up.
      write_attribute(8'hFF);
      repeat (12) queue_item(ACTION_PUT, CHAR_TAB);
      repeat (82) queue_item(ACTION_PUT, 8'($urandom_range(32, 126)));
      hold_requests++;
      repeat (12) queue_item(ACTION_PUT, 8'($urandom_range(0, 255)));
      wait_drained();

      for (int phase = 0; phase < 2; phase++) begin
         write_attribute(8'($urandom_range(0, 255)));
         phase_end = items_issued + 5;
         while (items_issued < phase_end)
            queue_random_segment();
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tcce_pkg.sv
rtl/core/tcce_step.sv
rtl/core/tcce_queue.sv
rtl/core/text_console_character_engine_top.sv
test/tb_top.sv
